/* src/sbmw_pkg.sv */
// ----------------------------------------------------------------------------
// sbmw_pkg
// Shared types and constants for the signed byte string to magnitude word
// converter.
// ----------------------------------------------------------------------------
package sbmw_pkg;

  localparam int unsigned ByteBits     = 8;
  localparam int unsigned WordBits     = 32;
  localparam int unsigned BytesPerWord = WordBits / ByteBits;
  localparam int unsigned ByteSelBits  = $clog2(BytesPerWord);
  localparam logic [ByteBits-1:0] SignMask = 8'h80;

  typedef struct packed {
    logic [ByteBits-1:0] byte_value;
    logic                last_byte;
  } in_item_t;

  typedef struct packed {
    logic [WordBits-1:0] word_value;
    logic                negative;
    logic                last_word;
    logic                overflow;
  } out_item_t;

  // top level sequencer states
  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // command from the sequencer to the conversion walk
  typedef struct packed {
    logic start;
    logic neg;
  } walk_cmd_t;

  // status from the conversion walk
  typedef struct packed {
    logic busy;
    logic done;
    logic any_nz;
  } walk_sts_t;

endpackage

/* src/sbmw_in_if.sv */
// ----------------------------------------------------------------------------
// sbmw_in_if
// Byte request channel: valid/ready handshake with one byte and a last flag.
// ----------------------------------------------------------------------------
interface sbmw_in_if;
  logic               valid;
  logic               ready;
  sbmw_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/sbmw_out_if.sv */
// ----------------------------------------------------------------------------
// sbmw_out_if
// Word request channel: valid/ready handshake with one magnitude word.
// ----------------------------------------------------------------------------
interface sbmw_out_if;
  logic                valid;
  logic                ready;
  sbmw_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/signed_bytes_to_magnitude_words.sv */
// ----------------------------------------------------------------------------
// signed_bytes_to_magnitude_words
// Converts a big-endian two's complement byte string into magnitude words,
// least significant word first, with a sign flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  takes one byte per request, most significant byte first; last_byte
//         marks the final byte. Bytes are taken one per cycle while loading.
//   out_o gives one request per kept 32-bit word, low word first; last_word
//         marks the top kept word. negative and overflow are the same on
//         every word of a string. Zero is reported positive.
//   Bytes past MAX_BYTES are dropped and overflow is set for that string.
// Sequence:
//   after the final byte the walk reads the byte store low end first, one
//   byte store read per cycle; the words are then read out one per cycle
//   from the word store read port while the receiver takes them.
//   in_i.ready is low from the final byte until the last word is taken.
// Reset clears all control state; both stores need no clearing pass.
// A stalled receiver simply holds the current word; the sequencer waits.
// ----------------------------------------------------------------------------
module signed_bytes_to_magnitude_words #(
  parameter int unsigned MAX_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sbmw_in_if.sink           in_i,
  sbmw_out_if.source        out_o
);

  localparam int unsigned MaxWords = (MAX_BYTES + sbmw_pkg::BytesPerWord - 1)
                                     / sbmw_pkg::BytesPerWord;
  localparam int unsigned BAW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned CW  = $clog2(MAX_BYTES + 1);
  localparam int unsigned WAW = (MaxWords > 1) ? $clog2(MaxWords) : 1;

  sbmw_pkg::state_e state_q, state_d;

  logic [CW-1:0]  count_q;          // bytes stored for this string
  logic           sign_q;           // sign bit of the first byte
  logic           ovf_q;            // bytes dropped in this string
  logic [WAW-1:0] emit_idx_q;       // next word to read out
  logic           emit_done_q;      // top word already read
  logic           out_valid_q;
  logic           out_last_q;

  logic           in_acc;
  logic           full;
  logic [BAW-1:0] last_lo;
  logic           issue;

  sbmw_pkg::walk_cmd_t walk_cmd;
  sbmw_pkg::walk_sts_t walk_sts;
  logic [WAW-1:0]      last_idx;

  logic                                byte_re;
  logic [BAW-1:0]                      byte_raddr;
  logic [sbmw_pkg::ByteBits-1:0]       byte_rdata;
  logic                                word_we;
  logic [WAW-1:0]                      word_waddr;
  logic [sbmw_pkg::WordBits-1:0]       word_wdata;
  logic [sbmw_pkg::WordBits-1:0]       word_rdata;

  // --- load side ------------------------------------------------------------
  assign in_i.ready = (state_q == sbmw_pkg::ST_LOAD);
  assign in_acc     = in_i.valid & in_i.ready;
  assign full       = (count_q == CW'(MAX_BYTES));
  // index of the least significant stored byte once the final byte lands
  assign last_lo    = full ? BAW'(MAX_BYTES - 1) : count_q[BAW-1:0];

  assign walk_cmd.start = in_acc & in_i.payload.last_byte;
  assign walk_cmd.neg   = (count_q == '0)
                          ? ((in_i.payload.byte_value & sbmw_pkg::SignMask) != '0)
                          : sign_q;

  sbmw_ram #(
    .WIDTH (sbmw_pkg::ByteBits),
    .DEPTH (MAX_BYTES)
  ) u_byte_store (
    .clk_i   (clk_i),
    .we_i    (in_acc & ~full),
    .waddr_i (count_q[BAW-1:0]),
    .wdata_i (in_i.payload.byte_value),
    .re_i    (byte_re),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  // --- negate and pack walk -------------------------------------------------
  sbmw_conv #(
    .BAW       (BAW),
    .WAW       (WAW)
  ) u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (walk_cmd),
    .last_lo_i    (last_lo),
    .sts_o        (walk_sts),
    .last_idx_o   (last_idx),
    .byte_re_o    (byte_re),
    .byte_raddr_o (byte_raddr),
    .byte_rdata_i (byte_rdata),
    .word_we_o    (word_we),
    .word_waddr_o (word_waddr),
    .word_wdata_o (word_wdata)
  );

  sbmw_ram #(
    .WIDTH (sbmw_pkg::WordBits),
    .DEPTH (MaxWords)
  ) u_word_store (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (word_waddr),
    .wdata_i (word_wdata),
    .re_i    (issue),
    .raddr_i (emit_idx_q),
    .rdata_o (word_rdata)
  );

  // --- emit side ------------------------------------------------------------
  // A read is issued when the output slot is free or being taken, so the
  // RAM read register itself serves as the output data register.
  assign issue = (state_q == sbmw_pkg::ST_EMIT) & ~emit_done_q
                 & (~out_valid_q | out_o.ready);

  assign out_o.valid              = out_valid_q;
  assign out_o.payload.word_value = word_rdata;
  assign out_o.payload.negative   = sign_q & walk_sts.any_nz;
  assign out_o.payload.last_word  = out_last_q;
  assign out_o.payload.overflow   = ovf_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbmw_pkg::ST_LOAD: begin
        if (walk_cmd.start) begin
          state_d = sbmw_pkg::ST_WALK;
        end
      end
      sbmw_pkg::ST_WALK: begin
        if (walk_sts.done) begin
          state_d = sbmw_pkg::ST_EMIT;
        end
      end
      sbmw_pkg::ST_EMIT: begin
        if (emit_done_q && (!out_valid_q || out_o.ready)) begin
          state_d = sbmw_pkg::ST_LOAD;
        end
      end
      default: state_d = sbmw_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbmw_pkg::ST_LOAD;
      count_q     <= '0;
      sign_q      <= 1'b0;
      ovf_q       <= 1'b0;
      emit_idx_q  <= '0;
      emit_done_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_acc) begin
        if (count_q == '0) begin
          sign_q <= walk_cmd.neg;
        end
        if (full) begin
          ovf_q <= 1'b1;
        end
        if (in_i.payload.last_byte) begin
          count_q <= '0;
        end else if (!full) begin
          count_q <= count_q + CW'(1);
        end
      end

      if (walk_sts.done) begin
        emit_idx_q  <= '0;
        emit_done_q <= 1'b0;
      end else if (issue) begin
        out_last_q <= (emit_idx_q == last_idx);
        if (emit_idx_q == last_idx) begin
          emit_done_q <= 1'b1;
        end else begin
          emit_idx_q <= emit_idx_q + WAW'(1);
        end
      end

      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // string finished: clear the drop flag for the next one
      if (state_q == sbmw_pkg::ST_EMIT && state_d == sbmw_pkg::ST_LOAD) begin
        ovf_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("byte request accepted while words are pending");

  a_final_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.payload.last_byte) |=> (walk_sts.busy && state_q == sbmw_pkg::ST_WALK))
    else $error("final byte did not start the conversion walk");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BYTES))
    else $error("byte count exceeds store depth");

  a_walk_idle_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbmw_pkg::ST_EMIT) |-> (!walk_sts.busy && !word_we))
    else $error("word store written while words are read out");
`endif

endmodule

/* src/sbmw_ram.sv */
// ----------------------------------------------------------------------------
// sbmw_ram
// Generic simple dual port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module sbmw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sbmw_conv.sv */
// ----------------------------------------------------------------------------
// sbmw_conv
// Conversion walk: reads stored bytes from the low end, negates them when
// the string is negative, packs them into words and writes the word store.
// ----------------------------------------------------------------------------
module sbmw_conv #(
  parameter int unsigned BAW       = 8,
  parameter int unsigned WAW       = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbmw_pkg::walk_cmd_t               cmd_i,
  input  logic [BAW-1:0]                    last_lo_i,
  output sbmw_pkg::walk_sts_t               sts_o,
  output logic [WAW-1:0]                    last_idx_o,
  // byte store read port
  output logic                              byte_re_o,
  output logic [BAW-1:0]                    byte_raddr_o,
  input  logic [sbmw_pkg::ByteBits-1:0]     byte_rdata_i,
  // word store write port
  output logic                              word_we_o,
  output logic [WAW-1:0]                    word_waddr_o,
  output logic [sbmw_pkg::WordBits-1:0]     word_wdata_o
);

  logic                              busy_q;
  logic                              iss_done_q;
  logic [BAW-1:0]                    rd_addr_q;
  logic                              pv_q;
  logic [BAW-1:0]                    lo_q;
  logic [BAW-1:0]                    last_lo_q;
  logic                              neg_q;
  logic                              carry_q;
  logic [sbmw_pkg::WordBits-1:0]     acc_q;
  logic [WAW-1:0]                    widx_q;
  logic [WAW-1:0]                    last_idx_q;
  logic                              any_nz_q;

  logic [sbmw_pkg::ByteBits:0]       sum;
  logic [sbmw_pkg::ByteBits-1:0]     opnd;
  logic [sbmw_pkg::ByteSelBits-1:0]  bsel;
  logic [sbmw_pkg::WordBits-1:0]     acc_d;
  logic                              word_done;
  logic                              at_end;

  assign byte_re_o    = busy_q & ~iss_done_q;
  assign byte_raddr_o = rd_addr_q;

  // invert and ripple the carry in from the low end
  assign opnd = neg_q ? ~byte_rdata_i : byte_rdata_i;
  assign sum  = {1'b0, opnd} + {{sbmw_pkg::ByteBits{1'b0}}, carry_q};
  assign bsel = lo_q[sbmw_pkg::ByteSelBits-1:0];

  always_comb begin
    acc_d = (bsel == '0) ? '0 : acc_q;
    acc_d = acc_d | ({{(sbmw_pkg::WordBits-sbmw_pkg::ByteBits){1'b0}},
                      sum[sbmw_pkg::ByteBits-1:0]} << {bsel, 3'b000});
  end

  assign at_end    = (lo_q == last_lo_q);
  assign word_done = pv_q & ((bsel == '1) | at_end);

  assign word_we_o    = word_done;
  assign word_waddr_o = widx_q;
  assign word_wdata_o = acc_d;

  assign sts_o.busy   = busy_q;
  assign sts_o.done   = pv_q & at_end;
  assign sts_o.any_nz = any_nz_q;
  assign last_idx_o   = last_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      iss_done_q <= 1'b1;
      pv_q       <= 1'b0;
      any_nz_q   <= 1'b0;
      last_idx_q <= '0;
    end else if (cmd_i.start) begin
      busy_q     <= 1'b1;
      iss_done_q <= 1'b0;
      pv_q       <= 1'b0;
      any_nz_q   <= 1'b0;
      last_idx_q <= '0;
    end else begin
      pv_q <= byte_re_o;
      if (byte_re_o && rd_addr_q == '0) begin
        iss_done_q <= 1'b1;
      end
      if (pv_q && at_end) begin
        busy_q <= 1'b0;
      end
      if (word_done && acc_d != '0) begin
        any_nz_q   <= 1'b1;
        last_idx_q <= widx_q;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rd_addr_q <= last_lo_i;
      last_lo_q <= last_lo_i;
      lo_q      <= '0;
      neg_q     <= cmd_i.neg;
      carry_q   <= cmd_i.neg;
      widx_q    <= '0;
    end else begin
      if (byte_re_o) begin
        rd_addr_q <= rd_addr_q - BAW'(1);
      end
      if (pv_q) begin
        lo_q    <= lo_q + BAW'(1);
        carry_q <= sum[sbmw_pkg::ByteBits];
        acc_q   <= acc_d;
      end
      if (word_done) begin
        widx_q <= widx_q + WAW'(1);
      end
    end
  end

endmodule

/* tb/sv/tb_signed_bytes_to_magnitude_words.sv */
// ----------------------------------------------------------------------------
// tb_signed_bytes_to_magnitude_words
// Self-checking bench for the signed byte string to magnitude word converter.
// Drives byte requests and takes word requests over valid/ready channels. A
// built-in predictor negates and packs each string and queues the words.
// Every word the block returns is checked against the oldest queued word.
// Stimulus: a directed table, then random strings under four idling phases.
// ----------------------------------------------------------------------------
module tb_signed_bytes_to_magnitude_words;

  localparam int unsigned MaxBytes    = 256;
  localparam int unsigned MaxWords    = MaxBytes / sbmw_pkg::BytesPerWord;
  localparam int unsigned CycleLimit  = 200_000;
  // walk of a full store, 64 words out, plus margin
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned NumPhases   = 4;

  // per phase: sender idle %, receiver stall %, byte budget
  localparam int unsigned SendIdlePct [NumPhases] = '{0, 55, 0, 22};
  localparam int unsigned RecvStallPct[NumPhases] = '{0, 0, 55, 22};
  localparam int unsigned PhaseBytes  [NumPhases] = '{30, 30, 290, 30};
  // phase that opens with an over-capacity string
  localparam int unsigned LongPhase = 2;

  // directed row: one byte request, with a typed-in word where it is obvious
  typedef struct packed {
    logic [sbmw_pkg::ByteBits-1:0] byte_value;
    logic                          last_byte;
    logic                          typed;
    logic [sbmw_pkg::WordBits-1:0] word_value;
    logic                          negative;
  } dir_row_t;

  localparam int unsigned NumDirRows = 24;
  localparam dir_row_t DirRows[NumDirRows] = '{
    // single bytes: zero stays positive, -1, most negative, most positive, +1
    '{8'h00, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 32'h0000_0001, 1'b1},
    '{8'h80, 1'b1, 1'b1, 32'h0000_0080, 1'b1},
    '{8'h7F, 1'b1, 1'b1, 32'h0000_007F, 1'b0},
    '{8'h01, 1'b1, 1'b1, 32'h0000_0001, 1'b0},
    // most negative 32-bit value, carry runs through every byte
    '{8'h80, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
    // -1 over five bytes: high word drops after negation
    '{8'hFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'hFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'hFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'hFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'hFF, 1'b1, 1'b1, 32'h0000_0001, 1'b1},
    // long zero: one word kept, positive
    '{8'h00, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    // 40-bit most negative value, two words: left to the predictor
    '{8'h80, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b0, 1'b0, 32'h0,         1'b0},
    '{8'h00, 1'b1, 1'b0, 32'h0,         1'b0}
  };

  logic clk;
  logic rst_n;

  sbmw_in_if  byte_ch ();
  sbmw_out_if word_ch ();

  signed_bytes_to_magnitude_words #(
    .MAX_BYTES (MaxBytes)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (word_ch)
  );

  // predictor state: bytes of the open string and its drop flag
  logic [sbmw_pkg::ByteBits-1:0] string_bytes[$];
  bit                            string_dropped;
  // words still owed by the block, oldest first
  sbmw_pkg::out_item_t           expected_words[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned err_count;
  int unsigned cycle_count;

  // 10 time units per cycle
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Negate (if the sign bit of the first byte is set), pack low word first,
  // drop high zero words but keep one; a zero result is always positive.
  function automatic void predict_magnitude_words();
    logic [sbmw_pkg::ByteBits-1:0] mag[$];
    logic [sbmw_pkg::WordBits-1:0] words[$];
    logic [sbmw_pkg::WordBits-1:0] w;
    logic [sbmw_pkg::ByteBits:0]   sum;
    bit                            neg;
    bit                            carry;
    int                            n;
    int                            nw;
    int                            pos;
    mag = string_bytes;
    n   = mag.size();
    neg = (n > 0) && ((mag[0] & sbmw_pkg::SignMask) != '0);
    if (neg) begin
      carry = 1'b1;
      for (int i = n - 1; i >= 0; i--) begin
        sum    = {1'b0, ~mag[i]} + carry;
        mag[i] = sum[sbmw_pkg::ByteBits-1:0];
        carry  = sum[sbmw_pkg::ByteBits];
      end
    end
    nw = (n + sbmw_pkg::BytesPerWord - 1) / sbmw_pkg::BytesPerWord;
    if (nw == 0) nw = 1;
    if (nw > MaxWords) nw = MaxWords;
    for (int k = 0; k < nw; k++) begin
      w = '0;
      for (int j = 0; j < sbmw_pkg::BytesPerWord; j++) begin
        // byte position counted from the low end
        pos = k * sbmw_pkg::BytesPerWord + j;
        if (pos < n) w[sbmw_pkg::ByteBits*j +: sbmw_pkg::ByteBits] = mag[n - 1 - pos];
      end
      words.push_back(w);
    end
    while (words.size() > 1 && words[words.size()-1] == '0) void'(words.pop_back());
    if (words.size() == 1 && words[0] == '0) neg = 1'b0;
    foreach (words[k]) begin
      expected_words.push_back('{word_value: words[k], negative: neg,
                                 last_word: (k == words.size() - 1),
                                 overflow: string_dropped});
    end
  endfunction

  // Account for one accepted byte; a final byte closes the string.
  function automatic void take_byte(sbmw_pkg::in_item_t req, bit typed,
                                    logic [sbmw_pkg::WordBits-1:0] typed_word,
                                    bit typed_neg);
    if (string_bytes.size() < MaxBytes) string_bytes.push_back(req.byte_value);
    else string_dropped = 1'b1;
    if (req.last_byte) begin
      if (typed) begin
        expected_words.push_back('{word_value: typed_word, negative: typed_neg,
                                   last_word: 1'b1, overflow: 1'b0});
      end else begin
        predict_magnitude_words();
      end
      string_bytes.delete();
      string_dropped = 1'b0;
    end
  endfunction

  // One byte request: random idle cycles first, then hold until accepted.
  // valid stays high into the next request when no gap is drawn.
  task automatic send_byte(sbmw_pkg::in_item_t req, bit typed,
                           logic [sbmw_pkg::WordBits-1:0] typed_word, bit typed_neg);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.payload <= req;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    take_byte(req, typed, typed_word, typed_neg);
  endtask

  // Byte content by fill style: 0 mixed, 1 mostly zero, 2 mostly ones.
  function automatic logic [sbmw_pkg::ByteBits-1:0] pick_byte(int unsigned fill);
    logic [sbmw_pkg::ByteBits-1:0] b;
    b = 8'($urandom);
    case (fill)
      0: begin
        case ($urandom_range(7))
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = sbmw_pkg::SignMask;
          3: b = ~sbmw_pkg::SignMask;
          default: ;
        endcase
      end
      1: if ($urandom_range(9) < 8) b = 8'h00;
      default: if ($urandom_range(9) < 8) b = 8'hFF;
    endcase
    return b;
  endfunction

  // A well-formed string of len bytes; the lead byte sets the sign.
  task automatic send_string(int unsigned len);
    int unsigned        fill;
    sbmw_pkg::in_item_t req;
    fill = $urandom_range(2);
    for (int unsigned i = 0; i < len; i++) begin
      req.byte_value = (i == 0) ? pick_byte(0) : pick_byte(fill);
      req.last_byte  = (i == len - 1);
      send_byte(req, 1'b0, '0, 1'b0);
    end
  endtask

  // Word side: check each accepted word, then redraw ready for next cycle.
  always @(posedge clk) begin
    sbmw_pkg::out_item_t exp_w;
    if (rst_n && word_ch.valid && word_ch.ready) begin
      if (expected_words.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("unexpected word: %h neg=%b last=%b ovf=%b",
                   word_ch.payload.word_value, word_ch.payload.negative,
                   word_ch.payload.last_word, word_ch.payload.overflow);
      end else begin
        exp_w = expected_words.pop_front();
        if (word_ch.payload.word_value !== exp_w.word_value ||
            word_ch.payload.negative   !== exp_w.negative   ||
            word_ch.payload.last_word  !== exp_w.last_word  ||
            word_ch.payload.overflow   !== exp_w.overflow) begin
          err_count++;
          if (err_count <= MaxReports)
            $display("word mismatch: exp %h neg=%b last=%b ovf=%b, got %h neg=%b last=%b ovf=%b",
                     exp_w.word_value, exp_w.negative, exp_w.last_word, exp_w.overflow,
                     word_ch.payload.word_value, word_ch.payload.negative,
                     word_ch.payload.last_word, word_ch.payload.overflow);
        end
      end
    end
    word_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned        sent;
    int unsigned        len;
    sbmw_pkg::in_item_t req;
    byte_ch.valid   = 1'b0;
    byte_ch.payload = '0;
    rst_n           = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    string_dropped  = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    for (int unsigned i = 0; i < NumDirRows; i++) begin
      req.byte_value = DirRows[i].byte_value;
      req.last_byte  = DirRows[i].last_byte;
      send_byte(req, DirRows[i].typed, DirRows[i].word_value, DirRows[i].negative);
    end

    // random strings, mostly short; one phase opens with an over-capacity
    // string so its last bytes are dropped and up to 64 words come back
    for (int unsigned p = 0; p < NumPhases; p++) begin
      send_idle_pct  = SendIdlePct[p];
      recv_stall_pct = RecvStallPct[p];
      sent = 0;
      if (p == LongPhase) begin
        sent = $urandom_range(MaxBytes + 3, MaxBytes + 1);
        send_string(sent);
      end
      while (sent < PhaseBytes[p]) begin
        if ($urandom_range(3) != 0) len = $urandom_range(8, 1);
        else len = $urandom_range(24, 9);
        send_string(len);
        sent += len;
      end
    end
    byte_ch.valid <= 1'b0;

    // drain: no stalls, then watch for stray words
    recv_stall_pct = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* signed_bytes_to_magnitude_words.f */
src/sbmw_pkg.sv
src/sbmw_in_if.sv
src/sbmw_out_if.sv
src/sbmw_ram.sv
src/sbmw_conv.sv
src/signed_bytes_to_magnitude_words.sv
tb/sv/tb_signed_bytes_to_magnitude_words.sv
